// ===== rtl/core/huffman_code_bit_packer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// huffman code bit packer assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// checked outside reset only
`define HCBP_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HCBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// widths, defaults and operation codes of the huffman code bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int SYMBOLS_DEF      = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int WORD_BITS = 32;
  localparam int BYTE_W    = 8;
  localparam int ACC_W     = 7;
  localparam int CNT_W     = 3;
  localparam int MAX_RES   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

// ===== rtl/core/hcbp_if.sv =====
// ----------------------------------------------------------------------------
// hcbp channel interfaces
// valid/ready channels for input items and packed output bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hcbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [hcbp_pkg::OP_W-1:0]      operation;
  logic [hcbp_pkg::SYM_W-1:0]     symbol;
  logic [hcbp_pkg::LEN_W-1:0]     code_length;
  logic [hcbp_pkg::WORD_BITS-1:0] code_bits;

  modport source (output valid, output operation, output symbol, output code_length,
                  output code_bits, input ready);
  modport sink (input valid, input operation, input symbol, input code_length,
                input code_bits, output ready);
endinterface

interface hcbp_out_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte;
  logic                        last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/core/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// huffman encoder with loadable code table and msb-first byte packing
// ----------------------------------------------------------------------------
// in_chan carries load, encode and flush items; out_chan carries packed bytes,
// with last set on the final byte that one item causes. both are valid/ready.
// a load writes the table on the beat it is accepted; an encode of the same
// symbol may follow in the very next cycle.
// a byte passes the table read register, then the output byte register, before
// it shows on out_chan.
// throughput: one item per cycle for items that emit nothing (loads, zero
// length codes) while no item waits in the read stage; an item that emits
// bytes holds the byte-wide output register until all are taken, one byte per
// cycle while out_chan.ready is high, and emits at most four bytes.
// reset clears the accumulator, the pipeline and one valid bit per table
// entry at once, so every code length reads as zero; no clearing pass.
// when the receiver stalls, the output register holds its byte; an item that
// emits bytes waits in the read stage, and in_chan.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit #(
  parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hcbp_in_if.sink    in_chan,
  hcbp_out_if.source out_chan
);

  localparam int AW    = $clog2(SYMBOLS);
  localparam int LIM   = (MAX_CODE_LEN < hcbp_pkg::WORD_BITS) ? MAX_CODE_LEN
                                                              : hcbp_pkg::WORD_BITS;
  localparam int WB    = hcbp_pkg::WORD_BITS;
  localparam int LW    = hcbp_pkg::LEN_W;
  localparam int BW    = hcbp_pkg::BYTE_W;
  localparam int AC    = hcbp_pkg::ACC_W;
  localparam int CW    = hcbp_pkg::CNT_W;
  localparam int MW    = LW + WB;
  localparam int TW    = AC + WB;
  localparam int BUF_W = hcbp_pkg::MAX_RES * BW;
  localparam int NW    = $clog2(hcbp_pkg::MAX_RES + 1);

  // input side
  logic                 in_acc;
  logic                 sym_ok;
  logic [AW-1:0]        idx;
  logic [LW-1:0]        len_sat;
  logic                 ram_we;
  logic [MW-1:0]        ram_rdata;
  logic [SYMBOLS-1:0]   vld_r;

  // read stage
  logic                 s1_valid_r;
  hcbp_pkg::op_t        s1_op_r;
  logic                 s1_hit_r;
  logic                 s1_adv;

  // packing
  logic [LW-1:0]        code_len;
  logic [WB-1:0]        code;
  logic [WB:0]          len_mask;
  logic [TW-1:0]        joined;
  logic [TW-1:0]        left_al;
  logic [LW-1:0]        total;
  logic [CW-1:0]        enc_cnt;
  logic [BW-1:0]        fl_byte;
  logic [BW-1:0]        fl_pad;
  logic [NW-1:0]        res_n;
  logic [BUF_W-1:0]     res_bytes;

  // accumulator and output register
  logic [AC-1:0]        acc_r;
  logic [AC-1:0]        acc_nxt;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;
  logic                 buf_valid_r;
  logic [BUF_W-1:0]     buf_data_r;
  logic [NW-1:0]        buf_left_r;
  logic                 buf_free;
  logic                 out_beat;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign sym_ok  = {1'b0, in_chan.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOLS);
  assign idx     = in_chan.symbol[AW-1:0];
  assign len_sat = (in_chan.code_length > LW'(LIM)) ? LW'(LIM) : in_chan.code_length;
  assign ram_we  = in_acc && sym_ok
                && (hcbp_pkg::op_t'(in_chan.operation) == hcbp_pkg::OP_LOAD);

  hcbp_ram #(
    .WIDTH (MW),
    .DEPTH (SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({len_sat, in_chan.code_bits}),
    .re    (in_acc),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // code lookup and bit joining
  assign code_len = s1_hit_r ? ram_rdata[MW-1:WB] : '0;
  assign len_mask = ((WB+1)'(1) << code_len) - (WB+1)'(1);
  assign code     = ram_rdata[WB-1:0] & len_mask[WB-1:0];
  assign joined   = ({{WB{1'b0}}, acc_r} << code_len) | {{AC{1'b0}}, code};
  assign total    = {{(LW-CW){1'b0}}, cnt_r} + code_len;
  assign left_al  = joined << (LW'(TW) - total);
  assign enc_cnt  = total[CW-1:0];
  assign fl_byte  = {acc_r, 1'b0} << (CW'(AC) - cnt_r);
  assign fl_pad   = BW'(BW) - {{(BW-CW){1'b0}}, cnt_r};

  always_comb begin
    res_n     = '0;
    res_bytes = '0;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    case (s1_op_r)
      hcbp_pkg::OP_ENCODE: begin
        res_n     = NW'(total[LW-1:CW]);
        res_bytes = left_al[TW-1:TW-BUF_W];
        acc_nxt   = joined[AC-1:0] & ({AC{1'b1}} >> (CW'(AC) - enc_cnt));
        cnt_nxt   = enc_cnt;
      end
      hcbp_pkg::OP_FLUSH: begin
        if (cnt_r != '0) begin
          res_n     = NW'(2);
          res_bytes = {fl_byte, fl_pad, {(BUF_W-2*BW){1'b0}}};
        end else begin
          res_n     = NW'(1);
          res_bytes = {fl_pad, {(BUF_W-BW){1'b0}}};
        end
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      default: begin
        res_n = '0;
      end
    endcase
  end

  assign out_beat       = buf_valid_r && out_chan.ready;
  assign buf_free       = !buf_valid_r || (out_chan.ready && (buf_left_r == NW'(1)));
  assign s1_adv         = s1_valid_r && ((res_n == '0) || buf_free);
  assign in_chan.ready  = !s1_valid_r || s1_adv;

  assign out_chan.valid    = buf_valid_r;
  assign out_chan.out_byte = buf_data_r[BUF_W-1:BUF_W-BW];
  assign out_chan.last     = (buf_left_r == NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      buf_valid_r <= 1'b0;
      buf_left_r  <= '0;
    end else begin
      if (ram_we) begin
        vld_r[idx] <= 1'b1;
      end
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
      end
      if (s1_adv && (res_n != '0)) begin
        buf_valid_r <= 1'b1;
        buf_left_r  <= res_n;
      end else if (out_beat) begin
        buf_left_r <= buf_left_r - NW'(1);
        if (buf_left_r == NW'(1)) begin
          buf_valid_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= hcbp_pkg::op_t'(in_chan.operation);
      s1_hit_r <= sym_ok && vld_r[idx];
    end
    if (s1_adv && (res_n != '0)) begin
      buf_data_r <= res_bytes;
    end else if (out_beat) begin
      buf_data_r <= buf_data_r << BW;
    end
  end

endmodule

// ===== rtl/core/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_port_checker
// port-level checks of the huffman code bit packer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_unit_defines.svh"

module hcbp_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hcbp_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  // stalled beat holds
  `HCBP_ASSERT_ON(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last), "output beat changed while stalled")

  // bytes of one item leave back to back
  `HCBP_ASSERT_ON(a_burst, out_valid && out_ready && !out_last |=> out_valid, "gap inside a multi-byte burst")

  // input only backs up behind a pending output byte
  `HCBP_ASSERT_ON(a_backpressure, in_valid && !in_ready |-> out_valid, "input stalled with no output pending")

  // reset empties the output register
  `HCBP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind huffman_code_bit_packer_unit hcbp_port_checker u_hcbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_last  (out_chan.last)
);

// ===== tb/hcbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_checker
// watches both channels of the bit packer, keeps its own copy of the code
// table and bit accumulator, predicts the packed bytes of every accepted
// beat and compares each output beat with the oldest predicted byte
// ----------------------------------------------------------------------------

module hcbp_checker (
  input  logic clk,
  input  logic rst_n,
  hcbp_in_if   in_mon,
  hcbp_out_if  out_mon,
  output int   errors,
  output int   pending
);

  import hcbp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic [WORD_BITS-1:0] code_bits_tbl [SYMBOLS_DEF];
  logic [LEN_W-1:0]     code_len_tbl  [SYMBOLS_DEF];
  logic [ACC_W-1:0]     acc_bits;
  logic [CNT_W-1:0]     acc_cnt;
  packed_byte_t         packed_q [$];
  int                   err_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t hcbp_checker: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void pack_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                    input logic [LEN_W-1:0] len,
                                    input logic [WORD_BITS-1:0] bits);
    logic [BYTE_W-1:0] acc;
    int                cnt;
    int                clen;
    int                n_out;
    int                i;
    packed_byte_t      pb;
    acc   = {1'b0, acc_bits};
    cnt   = acc_cnt;
    n_out = 0;
    case (op)
      OP_LOAD: begin
        clen = len;
        if (clen > MAX_CODE_LEN_DEF) clen = MAX_CODE_LEN_DEF;
        if (clen > WORD_BITS) clen = WORD_BITS;
        code_bits_tbl[sym] = bits;
        code_len_tbl[sym]  = LEN_W'(clen);
      end
      OP_ENCODE: begin
        clen = code_len_tbl[sym];
        for (i = clen - 1; i >= 0; i--) begin
          acc = {acc[BYTE_W-2:0], code_bits_tbl[sym][i]};
          cnt++;
          if (cnt == BYTE_W) begin
            pb.data = acc;
            pb.last = 1'b0;
            packed_q.push_back(pb);
            n_out++;
            acc = '0;
            cnt = 0;
          end
        end
        if (n_out > 0) begin
          pb = packed_q.pop_back();
          pb.last = 1'b1;
          packed_q.push_back(pb);
        end
        acc_bits = acc[ACC_W-1:0];
        acc_cnt  = CNT_W'(cnt);
      end
      OP_FLUSH: begin
        if (cnt != 0) begin
          pb.data = BYTE_W'(acc << (BYTE_W - cnt));
          pb.last = 1'b0;
          packed_q.push_back(pb);
        end
        pb.data = BYTE_W'(BYTE_W - cnt);
        pb.last = 1'b1;
        packed_q.push_back(pb);
        acc_bits = '0;
        acc_cnt  = '0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    packed_byte_t want;
    int           s;
    if (!rst_n) begin
      for (s = 0; s < SYMBOLS_DEF; s++) code_len_tbl[s] = '0;
      acc_bits = '0;
      acc_cnt  = '0;
      packed_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (packed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte=%02h last=%b",
                                    out_mon.out_byte, out_mon.last));
        end else begin
          want = packed_q.pop_front();
          if (out_mon.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      out_mon.out_byte, want.data));
          if (out_mon.last !== want.last)
            report_mismatch($sformatf("last %b, predicted %b (byte %02h)",
                                      out_mon.last, want.last, want.data));
        end
      end
      if (in_mon.valid && in_mon.ready)
        pack_item(in_mon.operation, in_mon.symbol, in_mon.code_length, in_mon.code_bits);
    end
    pending <= packed_q.size();
    errors  <= err_cnt;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives load, encode, flush and unused-code items into the bit packer with
// random gaps on both channels; hcbp_checker predicts and checks every byte
// ----------------------------------------------------------------------------

module tb_top;

  import hcbp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              RAND_ITEMS  = 460;
  localparam int              DRAIN_LIMIT = 50000;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   errors;
  int   pending;
  bit   loaded [SYMBOLS_DEF];
  int   loaded_syms [$];

  hcbp_in_if  in_chan ();
  hcbp_out_if out_chan ();

  huffman_code_bit_packer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hcbp_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [WORD_BITS-1:0] bits);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= op;
    in_chan.symbol      <= sym;
    in_chan.code_length <= len;
    in_chan.code_bits   <= bits;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (op == OP_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  initial begin
    #200000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int                   i;
    int                   r;
    int                   w;
    int                   drain;
    logic [SYM_W-1:0]     sym;
    logic [LEN_W-1:0]     len;
    tx_idle_pct         = 23;
    rx_idle_pct         = 70;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.operation   <= OP_LOAD;
    in_chan.symbol      <= '0;
    in_chan.code_length <= '0;
    in_chan.code_bits   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty flush, zero length, saturation, long codes, ignored fields
    push_item(OP_FLUSH,  8'd0,   6'd0,  32'h0);
    push_item(OP_LOAD,   8'd0,   6'd0,  32'hFFFF_FFFF);
    push_item(OP_ENCODE, 8'd0,   6'd0,  32'h0);
    push_item(OP_LOAD,   8'd255, 6'd32, 32'hFFFF_FFFF);
    push_item(OP_LOAD,   8'd1,   6'd1,  32'h0000_0001);
    push_item(OP_LOAD,   8'd2,   6'd63, 32'hA5A5_5A5A);
    push_item(OP_LOAD,   8'd3,   6'd7,  32'h0);
    push_item(OP_LOAD,   8'd128, 6'd33, 32'h0000_0001);
    push_item(OP_ENCODE, 8'd1,   6'd63, 32'hFFFF_FFFF);
    push_item(OP_FLUSH,  8'd255, 6'd63, 32'hFFFF_FFFF);
    push_item(OP_ENCODE, 8'd255, 6'd0,  32'h0);
    push_item(OP_ENCODE, 8'd1,   6'd0,  32'h0);
    push_item(OP_ENCODE, 8'd255, 6'd0,  32'h0);
    push_item(OP_ENCODE, 8'd2,   6'd0,  32'h0);
    push_item(OP_ENCODE, 8'd3,   6'd0,  32'h0);
    push_item(OP_UNUSED, 8'($urandom()), 6'($urandom()), 32'($urandom()));
    push_item(OP_ENCODE, 8'd128, 6'd0,  32'h0);
    push_item(OP_FLUSH,  8'd0,   6'd0,  32'h0);
    push_item(OP_LOAD,   8'd1,   6'd0,  32'h0000_0001);
    push_item(OP_ENCODE, 8'd1,   6'd0,  32'h0);
    push_item(OP_ENCODE, 8'd3,   6'd0,  32'h0);
    push_item(OP_FLUSH,  8'd0,   6'd0,  32'h0);

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        tx_idle_pct = 70;
        rx_idle_pct = 23;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 20) begin
        sym = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(15));
        w = $urandom_range(9);
        if (w == 0) len = '0;
        else if (w <= 6) len = 6'($urandom_range(12, 1));
        else if (w <= 8) len = 6'($urandom_range(32, 13));
        else len = 6'($urandom_range(63, 33));
        push_item(OP_LOAD, sym, len, 32'($urandom()));
      end else if (r < 85) begin
        sym = 8'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        push_item(OP_ENCODE, sym, 6'($urandom()), 32'($urandom()));
      end else if (r < 95) begin
        push_item(OP_FLUSH, 8'($urandom()), 6'($urandom()), 32'($urandom()));
      end else begin
        push_item(OP_UNUSED, 8'($urandom()), 6'($urandom()), 32'($urandom()));
      end
    end
    in_chan.valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
